@@ hw/rtl/crg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crg_pkg
// Shared types and constants of the camera ray generator.
// ----------------------------------------------------------------------------
package crg_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int CFG_ADDR_W     = 6;
    localparam int CFG_DATA_W     = 64;

    // register indexes
    typedef enum logic [2:0] {
        REG_FIRST_X   = 3'd0,
        REG_FIRST_Y   = 3'd1,
        REG_STEP_X    = 3'd2,
        REG_STEP_Y    = 3'd3,
        REG_ROT_RIGHT = 3'd4,
        REG_ROT_DOWN  = 3'd5,
        REG_ROT_BACK  = 3'd6,
        REG_ORIGIN    = 3'd7
    } cfg_reg_t;

    localparam logic signed [31:0] Q32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q32_MIN = 32'sh8000_0000;

    // reset values of the rotation rows (identity in Q2.14)
    localparam logic [47:0] ROT_RIGHT_RST = 48'h0000_0000_4000;
    localparam logic [47:0] ROT_DOWN_RST  = 48'h0000_4000_0000;
    localparam logic [47:0] ROT_BACK_RST  = 48'h4000_0000_0000;

    // reciprocal magnitude limit: below this 2^40/|d| no longer fits
    localparam logic [31:0] RECIP_MAG_LIMIT = 32'd512;

    typedef struct packed {
        logic [15:0] pixel_v;
        logic [15:0] pixel_u;
    } pixel_t;

    typedef struct packed {
        logic [2:0]         recip_saturated;
        logic signed [19:0] origin_z;
        logic signed [19:0] origin_y;
        logic signed [19:0] origin_x;
        logic signed [31:0] inv_z;
        logic signed [31:0] inv_y;
        logic signed [31:0] inv_x;
        logic signed [31:0] dir_z;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_x;
    } ray_t;

endpackage
`default_nettype wire

@@ hw/rtl/crg_viewport.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crg_viewport
// Viewport coordinate of one axis: first + step * coord, rounded to Q8.24.
// Two register stages: multiply, then add, round and saturate.
// ----------------------------------------------------------------------------
module crg_viewport #(
    parameter int COORD_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  valid_in,
    input  wire logic signed [31:0]    first,
    input  wire logic signed [31:0]    step,
    input  wire logic [COORD_BITS-1:0] coord,
    output logic                       valid_out,
    output logic signed [31:0]         point
);
    import crg_pkg::*;

    localparam int PROD_W = 32 + COORD_BITS + 1;
    localparam int ACC_W  = PROD_W + 1;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(Q32_MAX);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(Q32_MIN);

    logic                      v1_reg;
    logic                      v2_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [ACC_W-1:0]   acc;
    logic signed [ACC_W-1:0]   acc_sh;
    logic signed [31:0]        point_reg;
    logic signed [31:0]        point_next;

    // step times coordinate
    always_comb
    begin
        prod_next = step * $signed({1'b0, coord});
    end

    // add first pixel in Q.28, round half up, saturate
    always_comb
    begin
        acc    = (ACC_W'(first) <<< 4) + ACC_W'(prod_reg) + ACC_W'(8);
        acc_sh = acc >>> 4;
        if (acc_sh > SAT_HI)
            point_next = Q32_MAX;
        else if (acc_sh < SAT_LO)
            point_next = Q32_MIN;
        else
            point_next = acc_sh[31:0];
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    // data stages
    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        point_reg <= point_next;
    end

    assign valid_out = v2_reg;
    assign point     = point_reg;

endmodule
`default_nettype wire

@@ hw/rtl/crg_rotate.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crg_rotate
// Viewport point times camera rotation, all three axes.
// Two register stages: products, then sum, round and saturate to Q8.24.
// ----------------------------------------------------------------------------
module crg_rotate (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               valid_in,
    input  wire logic signed [31:0] px,
    input  wire logic signed [31:0] py,
    input  wire logic [47:0]        rot_right,
    input  wire logic [47:0]        rot_down,
    input  wire logic [47:0]        rot_back,
    output logic                    valid_out,
    output logic [2:0][31:0]        dir
);
    import crg_pkg::*;

    localparam int SUM_W = 50;
    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(Q32_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(Q32_MIN);

    logic                      v1_reg;
    logic                      v2_reg;
    logic signed [47:0]        pr_reg   [3];
    logic signed [47:0]        pr_next  [3];
    logic signed [47:0]        pd_reg   [3];
    logic signed [47:0]        pd_next  [3];
    logic signed [15:0]        eb_reg   [3];
    logic signed [SUM_W-1:0]   sum      [3];
    logic signed [SUM_W-1:0]   sum_sh   [3];
    logic [2:0][31:0]          dir_reg;
    logic [2:0][31:0]          dir_next;

    // per-axis products
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            pr_next[a] = px * $signed(rot_right[16*a +: 16]);
            pd_next[a] = py * $signed(rot_down[16*a +: 16]);
        end
    end

    // sum with z = -1, round half up to Q8.24, saturate
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            sum[a] = SUM_W'(pr_reg[a]) + SUM_W'(pd_reg[a])
                   - (SUM_W'(eb_reg[a]) <<< 24) + SUM_W'(8192);
            sum_sh[a] = sum[a] >>> 14;
            if (sum_sh[a] > SAT_HI)
                dir_next[a] = Q32_MAX;
            else if (sum_sh[a] < SAT_LO)
                dir_next[a] = Q32_MIN;
            else
                dir_next[a] = sum_sh[a][31:0];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    // data stages
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 3; a++)
        begin
            pr_reg[a] <= pr_next[a];
            pd_reg[a] <= pd_next[a];
            eb_reg[a] <= $signed(rot_back[16*a +: 16]);
        end
        dir_reg <= dir_next;
    end

    assign valid_out = v2_reg;
    assign dir       = dir_reg;

endmodule
`default_nettype wire

@@ hw/rtl/crg_recip.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// crg_recip
// Pipelined reciprocal 2^40 / |d| rounded half up, one quotient bit per stage.
// Entry stage, 32 restoring division stages, output stage. The direction
// travels along so it leaves together with its reciprocal.
// ----------------------------------------------------------------------------
module crg_recip (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               valid_in,
    input  wire logic signed [31:0] d,
    output logic                    valid_out,
    output logic signed [31:0]      dir_out,
    output logic signed [31:0]      inv,
    output logic                    sat
);
    import crg_pkg::*;

    localparam int STAGES = 32;

    logic              vld_reg [STAGES+1];
    logic [32:0]       rem_reg [STAGES+1];
    logic [31:0]       quo_reg [STAGES+1];
    logic [31:0]       mag_reg [STAGES+1];
    logic [31:0]       num_reg [STAGES+1];
    logic signed [31:0] d_reg  [STAGES+1];
    logic              neg_reg [STAGES+1];
    logic              sat_reg [STAGES+1];

    logic              in_neg;
    logic [31:0]       in_mag;
    logic              in_sat;

    logic              out_vld_reg;
    logic signed [31:0] out_d_reg;
    logic signed [31:0] out_inv_reg;
    logic signed [31:0] out_inv_next;
    logic              out_sat_reg;

    // sign, magnitude and early saturation check
    always_comb
    begin
        in_neg = d[31];
        in_mag = in_neg ? (32'd0 - d) : d;
        if (in_neg)
            in_sat = (in_mag < RECIP_MAG_LIMIT);
        else
            in_sat = (in_mag <= RECIP_MAG_LIMIT);
    end

    // entry stage: remainder starts at the top bits of 2^40 + |d|/2
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else
            vld_reg[0] <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= 33'd256;
        quo_reg[0] <= '0;
        mag_reg[0] <= in_mag;
        num_reg[0] <= {1'b0, in_mag[31:1]};
        d_reg[0]   <= d;
        neg_reg[0] <= in_neg;
        sat_reg[0] <= in_sat;
    end

    // division stages
    for (genvar k = 1; k <= STAGES; k++)
    begin : g_div
        logic [32:0] rem_sh;
        logic [32:0] rem_next;
        logic        qbit;

        always_comb
        begin
            rem_sh = {rem_reg[k-1][31:0], num_reg[k-1][STAGES-k]};
            qbit   = (rem_sh >= {1'b0, mag_reg[k-1]});
            rem_next = qbit ? (rem_sh - {1'b0, mag_reg[k-1]}) : rem_sh;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else
                vld_reg[k] <= vld_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= rem_next;
            quo_reg[k] <= {quo_reg[k-1][30:0], qbit};
            mag_reg[k] <= mag_reg[k-1];
            num_reg[k] <= num_reg[k-1];
            d_reg[k]   <= d_reg[k-1];
            neg_reg[k] <= neg_reg[k-1];
            sat_reg[k] <= sat_reg[k-1];
        end
    end

    // sign and saturation of the quotient
    always_comb
    begin
        if (sat_reg[STAGES])
            out_inv_next = neg_reg[STAGES] ? Q32_MIN : Q32_MAX;
        else if (neg_reg[STAGES])
            out_inv_next = $signed(32'd0 - quo_reg[STAGES]);
        else
            out_inv_next = $signed(quo_reg[STAGES]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else
            out_vld_reg <= vld_reg[STAGES];
    end

    always_ff @(posedge clk)
    begin
        out_d_reg   <= d_reg[STAGES];
        out_inv_reg <= out_inv_next;
        out_sat_reg <= sat_reg[STAGES];
    end

    assign valid_out = out_vld_reg;
    assign dir_out   = out_d_reg;
    assign inv       = out_inv_reg;
    assign sat       = out_sat_reg;

endmodule
`default_nettype wire

@@ hw/rtl/camera_ray_generator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// camera_ray_generator
// Pinhole camera primary ray generation in fixed point.
// ----------------------------------------------------------------------------
// Takes one pixel per clock (busy stays low) and returns each ray on the
// result port with a one-cycle done strobe. Each ray passes two stages of
// viewport multiply and round, two stages of rotation multiply and sum, and a
// 34-stage reciprocal pipeline that resolves one quotient bit per stage. The
// receiver must take every beat as it appears. Registers are written over
// the APB port at byte address 8*index and may only change while no pixel
// is in flight.
// ----------------------------------------------------------------------------
module camera_ray_generator #(
    parameter int COORD_BITS = crg_pkg::COORD_BITS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire crg_pkg::pixel_t                  pixel,
    output logic                                  done,
    output crg_pkg::ray_t                         result,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [crg_pkg::CFG_ADDR_W-1:0]   paddr,
    input  wire logic [crg_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [crg_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                  pready
);
    import crg_pkg::*;

    logic signed [31:0] first_x_reg;
    logic signed [31:0] first_y_reg;
    logic signed [31:0] step_x_reg;
    logic signed [31:0] step_y_reg;
    logic [47:0]        rot_right_reg;
    logic [47:0]        rot_down_reg;
    logic [47:0]        rot_back_reg;
    logic [59:0]        origin_reg;

    cfg_reg_t           cfg_idx;
    logic               cfg_wr;

    logic [23:0]        u_ext;
    logic [23:0]        v_ext;
    logic               in_valid;
    logic [1:0]         vp_valid;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic               rot_valid;
    logic [2:0][31:0]   rot_dir;
    logic [2:0]         rc_valid;
    logic signed [31:0] rc_dir [3];
    logic signed [31:0] rc_inv [3];
    logic [2:0]         rc_sat;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_idx = cfg_reg_t'(paddr[5:3]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_x_reg   <= '0;
            first_y_reg   <= '0;
            step_x_reg    <= '0;
            step_y_reg    <= '0;
            rot_right_reg <= ROT_RIGHT_RST;
            rot_down_reg  <= ROT_DOWN_RST;
            rot_back_reg  <= ROT_BACK_RST;
            origin_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_FIRST_X:   first_x_reg   <= pwdata[31:0];
                REG_FIRST_Y:   first_y_reg   <= pwdata[31:0];
                REG_STEP_X:    step_x_reg    <= pwdata[31:0];
                REG_STEP_Y:    step_y_reg    <= pwdata[31:0];
                REG_ROT_RIGHT: rot_right_reg <= pwdata[47:0];
                REG_ROT_DOWN:  rot_down_reg  <= pwdata[47:0];
                REG_ROT_BACK:  rot_back_reg  <= pwdata[47:0];
                REG_ORIGIN:    origin_reg    <= pwdata[59:0];
                default:       ;
            endcase
        end
    end

    // register read back
    always_comb
    begin
        unique case (cfg_idx)
            REG_FIRST_X:   prdata = 64'(unsigned'(first_x_reg));
            REG_FIRST_Y:   prdata = 64'(unsigned'(first_y_reg));
            REG_STEP_X:    prdata = 64'(unsigned'(step_x_reg));
            REG_STEP_Y:    prdata = 64'(unsigned'(step_y_reg));
            REG_ROT_RIGHT: prdata = 64'(rot_right_reg);
            REG_ROT_DOWN:  prdata = 64'(rot_down_reg);
            REG_ROT_BACK:  prdata = 64'(rot_back_reg);
            REG_ORIGIN:    prdata = 64'(origin_reg);
            default:       prdata = '0;
        endcase
    end

    // input beat
    assign busy     = 1'b0;
    assign in_valid = start && !busy;
    assign u_ext    = 24'(pixel.pixel_u);
    assign v_ext    = 24'(pixel.pixel_v);

    // viewport point
    crg_viewport #(.COORD_BITS(COORD_BITS)) u_vp_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (in_valid),
        .first     (first_x_reg),
        .step      (step_x_reg),
        .coord     (u_ext[COORD_BITS-1:0]),
        .valid_out (vp_valid[0]),
        .point     (px)
    );

    crg_viewport #(.COORD_BITS(COORD_BITS)) u_vp_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (in_valid),
        .first     (first_y_reg),
        .step      (step_y_reg),
        .coord     (v_ext[COORD_BITS-1:0]),
        .valid_out (vp_valid[1]),
        .point     (py)
    );

    // rotation into world space
    crg_rotate u_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (&vp_valid),
        .px        (px),
        .py        (py),
        .rot_right (rot_right_reg),
        .rot_down  (rot_down_reg),
        .rot_back  (rot_back_reg),
        .valid_out (rot_valid),
        .dir       (rot_dir)
    );

    // per-axis reciprocal
    for (genvar a = 0; a < 3; a++)
    begin : g_recip
        crg_recip u_recip (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (rot_valid),
            .d         ($signed(rot_dir[a])),
            .valid_out (rc_valid[a]),
            .dir_out   (rc_dir[a]),
            .inv       (rc_inv[a]),
            .sat       (rc_sat[a])
        );
    end

    // result beat
    assign done = &rc_valid;

    always_comb
    begin
        result.dir_x           = rc_dir[0];
        result.dir_y           = rc_dir[1];
        result.dir_z           = rc_dir[2];
        result.inv_x           = rc_inv[0];
        result.inv_y           = rc_inv[1];
        result.inv_z           = rc_inv[2];
        result.origin_x        = $signed(origin_reg[19:0]);
        result.origin_y        = $signed(origin_reg[39:20]);
        result.origin_z        = $signed(origin_reg[59:40]);
        result.recip_saturated = rc_sat;
    end

    // a zero dir_x always saturates its reciprocal
    a_zero_dir_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.dir_x == 32'sd0) |-> result.recip_saturated[0])
        else $error("zero dir_x without saturation flag");

    // a saturated y reciprocal sits at one of the two limits
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.recip_saturated[1] |->
            (result.inv_y == Q32_MAX) || (result.inv_y == Q32_MIN))
        else $error("saturated inv_y not at a limit");

    // an unsaturated z reciprocal carries the sign of its direction
    a_recip_sign: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.recip_saturated[2] |-> (result.inv_z[31] == result.dir_z[31]))
        else $error("inv_z sign differs from dir_z");

endmodule
`default_nettype wire

@@ sim/camera_ray_generator_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// camera_ray_generator_test
// Self-checking bench for the pinhole camera ray generator.
// ----------------------------------------------------------------------------
// Walks a short directed table under reset identity, a degenerate rotation and
// tiny directions, then runs random pixels under both extremes, all bits set,
// raw random registers and realistic cameras. Pixels without a typed expectation
// go through a local fixed-point camera model. Each done beat is then compared
// field by field against the oldest pending ray.
// ----------------------------------------------------------------------------
module camera_ray_generator_test;
    import crg_pkg::*;

    localparam int  PIPE_DEPTH  = 38;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  PHASES      = 8;
    localparam int  PER_PHASE   = 85;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    pixel_t                pixel = '0;
    logic                  done;
    ray_t                  result;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // typed expectation travels with the pixel beat
    logic                  use_typed = 1'b0;
    ray_t                  typed_ray = '0;

    // camera settings as the block should hold them
    logic signed [31:0]    cam_first_x, cam_first_y, cam_step_x, cam_step_y;
    logic [47:0]           cam_right, cam_down, cam_back;
    logic [59:0]           cam_origin;

    ray_t                  pending_rays[$];
    int                    errors = 0;
    int                    cycles = 0;
    bit                    idle_on = 1'b1;

    camera_ray_generator u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .pixel   (pixel),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint clamp32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    // viewport coordinate: exact Q.28, round half up to Q8.24
    function automatic longint viewport_coord(longint first, longint step, logic [15:0] c);
        longint acc;
        acc = first * 16 + step * longint'({48'd0, c});
        return clamp32((acc + 8) >>> 4);
    endfunction

    // 2^40 / |d| rounded half up, signed and saturated
    function automatic longint recip_q16(longint d, output bit sat);
        longint unsigned mag;
        longint unsigned q;
        sat = 1'b0;
        if (d == 0)
        begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        mag = (d < 0) ? longint'(-d) : longint'(d);
        q = ((64'd1 << 40) + (mag >> 1)) / mag;
        if (d > 0)
        begin
            if (q > 64'd2147483647)
            begin
                sat = 1'b1;
                return 64'sd2147483647;
            end
            return longint'(q);
        end
        if (q > (64'd1 << 31))
        begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return -longint'(q);
    endfunction

    function automatic ray_t trace_pixel(pixel_t p);
        longint px, py, pz, sum, d, r;
        longint er, ed, eb;
        bit     sat;
        ray_t   ray;
        logic [31:0] dirs[3];
        logic [31:0] invs[3];
        px = viewport_coord(cam_first_x, cam_step_x, p.pixel_u);
        py = viewport_coord(cam_first_y, cam_step_y, p.pixel_v);
        pz = -(64'sd1 <<< 24);
        ray = '0;
        for (int a = 0; a < 3; a++)
        begin
            er = $signed(cam_right[a*16 +: 16]);
            ed = $signed(cam_down[a*16 +: 16]);
            eb = $signed(cam_back[a*16 +: 16]);
            sum = px * er + py * ed + pz * eb;
            d = clamp32((sum + (64'sd1 <<< 13)) >>> 14);
            r = recip_q16(d, sat);
            dirs[a] = d[31:0];
            invs[a] = r[31:0];
            ray.recip_saturated[a] = sat;
        end
        ray.dir_x    = dirs[0];
        ray.dir_y    = dirs[1];
        ray.dir_z    = dirs[2];
        ray.inv_x    = invs[0];
        ray.inv_y    = invs[1];
        ray.inv_z    = invs[2];
        ray.origin_x = cam_origin[19:0];
        ray.origin_y = cam_origin[39:20];
        ray.origin_z = cam_origin[59:40];
        return ray;
    endfunction

    // accepted pixel beats
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            pending_rays.push_back(use_typed ? typed_ray : trace_pixel(pixel));
    end

    // ray beats against the oldest expectation
    always @(posedge clk)
    begin
        ray_t e;
        if (rst_n && done)
        begin
            if (pending_rays.size() == 0)
            begin
                $error("unexpected ray beat");
                errors++;
            end
            else
            begin
                e = pending_rays.pop_front();
                if (result.dir_x !== e.dir_x)
                begin
                    $error("dir_x exp %h got %h", e.dir_x, result.dir_x);
                    errors++;
                end
                if (result.dir_y !== e.dir_y)
                begin
                    $error("dir_y exp %h got %h", e.dir_y, result.dir_y);
                    errors++;
                end
                if (result.dir_z !== e.dir_z)
                begin
                    $error("dir_z exp %h got %h", e.dir_z, result.dir_z);
                    errors++;
                end
                if (result.inv_x !== e.inv_x)
                begin
                    $error("inv_x exp %h got %h", e.inv_x, result.inv_x);
                    errors++;
                end
                if (result.inv_y !== e.inv_y)
                begin
                    $error("inv_y exp %h got %h", e.inv_y, result.inv_y);
                    errors++;
                end
                if (result.inv_z !== e.inv_z)
                begin
                    $error("inv_z exp %h got %h", e.inv_z, result.inv_z);
                    errors++;
                end
                if (result.origin_x !== e.origin_x)
                begin
                    $error("origin_x exp %h got %h", e.origin_x, result.origin_x);
                    errors++;
                end
                if (result.origin_y !== e.origin_y)
                begin
                    $error("origin_y exp %h got %h", e.origin_y, result.origin_y);
                    errors++;
                end
                if (result.origin_z !== e.origin_z)
                begin
                    $error("origin_z exp %h got %h", e.origin_z, result.origin_z);
                    errors++;
                end
                if (result.recip_saturated !== e.recip_saturated)
                begin
                    $error("recip_saturated exp %b got %b",
                           e.recip_saturated, result.recip_saturated);
                    errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[camera_ray_generator] ERROR");
            $finish;
        end
    end

    // register write over the config port, model updated alongside
    task automatic write_reg(cfg_reg_t idx, logic [63:0] value);
        case (idx)
            REG_FIRST_X:   cam_first_x = value[31:0];
            REG_FIRST_Y:   cam_first_y = value[31:0];
            REG_STEP_X:    cam_step_x  = value[31:0];
            REG_STEP_Y:    cam_step_y  = value[31:0];
            REG_ROT_RIGHT: cam_right   = value[47:0];
            REG_ROT_DOWN:  cam_down    = value[47:0];
            REG_ROT_BACK:  cam_back    = value[47:0];
            default:       cam_origin  = value[59:0];
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_W'({idx, 3'b000});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk iff pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // let the pipeline empty before touching registers
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_rays.size() != 0)
            @(posedge clk);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    // one pixel beat, sometimes followed by a random sender gap
    task automatic send_pixel(logic [15:0] u, logic [15:0] v, bit typed, ray_t tr);
        start     <= 1'b1;
        pixel     <= '{pixel_v: v, pixel_u: u};
        use_typed <= typed;
        typed_ray <= tr;
        @(posedge clk iff !busy);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    function automatic logic [47:0] random_row();
        logic [47:0] row;
        for (int a = 0; a < 3; a++)
            row[a*16 +: 16] = 16'($signed($urandom_range(0, 32768)) - 16384);
        return row;
    endfunction

    typedef struct {
        logic [15:0] u;
        logic [15:0] v;
    } pixel_row_t;

    pixel_row_t reset_rows[6] = '{
        '{16'h0000, 16'h0000}, '{16'hFFFF, 16'hFFFF}, '{16'h0000, 16'hFFFF},
        '{16'hFFFF, 16'h0000}, '{16'h8000, 16'h0001}, '{16'h5555, 16'hAAAA}
    };

    initial
    begin
        ray_t  reset_ray;
        ray_t  none;
        logic [15:0] u, v;

        cam_first_x = '0; cam_first_y = '0; cam_step_x = '0; cam_step_y = '0;
        cam_right = ROT_RIGHT_RST; cam_down = ROT_DOWN_RST; cam_back = ROT_BACK_RST;
        cam_origin = '0;
        none = '0;

        // reset camera looks straight down -z from the origin
        reset_ray = '0;
        reset_ray.dir_z           = -32'sd16777216;
        reset_ray.inv_x           = Q32_MAX;
        reset_ray.inv_y           = Q32_MAX;
        reset_ray.inv_z           = -32'sd65536;
        reset_ray.recip_saturated = 3'b011;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, coordinate extremes
        foreach (reset_rows[i])
            send_pixel(reset_rows[i].u, reset_rows[i].v, 1'b1, reset_ray);
        drain();

        // directed: zero direction on every axis
        write_reg(REG_ROT_BACK, 48'd0);
        send_pixel(16'h1234, 16'h4321, 1'b0, none);
        drain();

        // directed: tiny directions of both signs saturate; at 512 only the positive one does
        write_reg(REG_ROT_BACK, ROT_BACK_RST);
        write_reg(REG_FIRST_X, 32'd300);
        write_reg(REG_FIRST_Y, -32'sd300);
        send_pixel(16'h0000, 16'h0000, 1'b0, none);
        drain();
        write_reg(REG_FIRST_X, 32'd512);
        write_reg(REG_FIRST_Y, -32'sd512);
        send_pixel(16'h0000, 16'h0000, 1'b0, none);
        send_pixel(16'h0001, 16'h0001, 1'b0, none);
        drain();

        // random phases under a series of camera settings
        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    // largest positive everywhere
                    write_reg(REG_FIRST_X, 32'h7FFF_FFFF);
                    write_reg(REG_FIRST_Y, 32'h7FFF_FFFF);
                    write_reg(REG_STEP_X, 32'h7FFF_FFFF);
                    write_reg(REG_STEP_Y, 32'h7FFF_FFFF);
                    write_reg(REG_ROT_RIGHT, 48'h7FFF_7FFF_7FFF);
                    write_reg(REG_ROT_DOWN, 48'h7FFF_7FFF_7FFF);
                    write_reg(REG_ROT_BACK, 48'h7FFF_7FFF_7FFF);
                    write_reg(REG_ORIGIN, 60'h7FFFF_7FFFF_7FFFF);
                end
                1:
                begin
                    // most negative everywhere
                    write_reg(REG_FIRST_X, 32'h8000_0000);
                    write_reg(REG_FIRST_Y, 32'h8000_0000);
                    write_reg(REG_STEP_X, 32'h8000_0000);
                    write_reg(REG_STEP_Y, 32'h8000_0000);
                    write_reg(REG_ROT_RIGHT, 48'h8000_8000_8000);
                    write_reg(REG_ROT_DOWN, 48'h8000_8000_8000);
                    write_reg(REG_ROT_BACK, 48'h8000_8000_8000);
                    write_reg(REG_ORIGIN, 60'h80000_80000_80000);
                end
                2:
                begin
                    // all bits set in every register
                    write_reg(REG_FIRST_X, '1);
                    write_reg(REG_FIRST_Y, '1);
                    write_reg(REG_STEP_X, '1);
                    write_reg(REG_STEP_Y, '1);
                    write_reg(REG_ROT_RIGHT, '1);
                    write_reg(REG_ROT_DOWN, '1);
                    write_reg(REG_ROT_BACK, '1);
                    write_reg(REG_ORIGIN, '1);
                end
                3:
                begin
                    // raw random register contents
                    write_reg(REG_FIRST_X, {$urandom, $urandom});
                    write_reg(REG_FIRST_Y, {$urandom, $urandom});
                    write_reg(REG_STEP_X, {$urandom, $urandom});
                    write_reg(REG_STEP_Y, {$urandom, $urandom});
                    write_reg(REG_ROT_RIGHT, {$urandom, $urandom});
                    write_reg(REG_ROT_DOWN, {$urandom, $urandom});
                    write_reg(REG_ROT_BACK, {$urandom, $urandom});
                    write_reg(REG_ORIGIN, {$urandom, $urandom});
                end
                default:
                begin
                    // realistic camera: viewport about +-1, small steps
                    write_reg(REG_FIRST_X, -32'sd16777216 + $urandom_range(0, 65535));
                    write_reg(REG_FIRST_Y, 32'sd16777216 - $urandom_range(0, 65535));
                    write_reg(REG_STEP_X, $urandom_range(1024, 131072));
                    write_reg(REG_STEP_Y, -$urandom_range(1024, 131072));
                    write_reg(REG_ROT_RIGHT, random_row());
                    write_reg(REG_ROT_DOWN, random_row());
                    write_reg(REG_ROT_BACK, random_row());
                    write_reg(REG_ORIGIN, {$urandom, $urandom});
                end
            endcase
            // no sender gaps in the last phase
            idle_on = (ph < PHASES - 1);
            for (int n = 0; n < PER_PHASE; n++)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    u = 16'($urandom);
                    v = 16'($urandom);
                end
                else
                begin
                    u = 16'($urandom_range(0, 4095));
                    v = 16'($urandom_range(0, 4095));
                end
                send_pixel(u, v, 1'b0, none);
            end
            drain();
        end

        if (errors == 0)
            $display("[camera_ray_generator] OK");
        else
            $display("[camera_ray_generator] ERROR");
        $finish;
    end

endmodule
`default_nettype wire
